// ===== rtl/median_filter_3x3_macros.svh =====
// Assertion macros shared by the median filter RTL.
`ifndef MEDIAN_FILTER_3X3_MACROS_SVH
`define MEDIAN_FILTER_3X3_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MF3_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MF3_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mf3_pkg.sv =====
// Shared types, constants and helpers for the 3x3 median filter.
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Frame dimension after reset (clamped to the instance maximum)
  localparam int DIM_RESET = 512;

  // Input action code: flush beat drains one pending result
  localparam logic ACT_FLUSH = 1'b1;

  // 3x3 window geometry
  localparam int WIN_CELLS = 9;
  localparam int WIN_MID   = 4;

  typedef logic [WIN_CELLS-1:0] cell_mask_t;

  // Border handling: cells outside the frame are replaced by the lowest
  // or highest gray level so a fixed median-of-9 picks the clipped median.
  typedef struct packed {
    cell_mask_t keep;
    cell_mask_t low;
  } pad_t;

  // Per-beat control carried down the pipeline
  typedef struct packed {
    logic due;
    logic last;
    pad_t pad;
  } item_ctl_t;

  // Builds the keep/low masks from the four border flags. For n kept
  // cells the upper median sits at index n/2, so 4 - n/2 excluded cells
  // go low and the rest go high.
  function automatic pad_t pad_masks(input logic top_ok, input logic bot_ok,
                                     input logic left_ok, input logic right_ok);
    pad_t       m;
    logic [3:0] n;
    logic [3:0] k;
    logic [3:0] seen;
    logic       row_ok;
    logic       col_ok;
    int         r;
    int         c;
    m    = '0;
    n    = '0;
    seen = '0;
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        row_ok = (r != 0 || top_ok) && (r != 2 || bot_ok);
        col_ok = (c != 0 || left_ok) && (c != 2 || right_ok);
        m.keep[r*3 + c] = row_ok && col_ok;
        n = n + 4'(m.keep[r*3 + c]);
      end
    end
    k = 4'(WIN_MID) - (n >> 1);
    for (r = 0; r < WIN_CELLS; r++) begin
      if (!m.keep[r]) begin
        m.low[r] = (seen < k);
        seen     = seen + 4'd1;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mf3_channels.sv =====
// Channel interfaces of the median filter: pixel input, result output, config writes.
`timescale 1ns / 1ps
`default_nettype none

interface mf3_in_if #(parameter int PIXEL_BITS = 8) ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface mf3_out_if #(parameter int PIXEL_BITS = 8) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] median_out;
  logic                  frame_last;
  logic [PIXEL_BITS-1:0] frame_max;

  modport source (output valid, output median_out, output frame_last,
                  output frame_max, input ready);
  modport sink   (input valid, input median_out, input frame_last,
                  input frame_max, output ready);
endinterface

interface mf3_cfg_if ();
  logic                             valid;
  logic                             ready;
  logic [mf3_pkg::CFG_IDX_W-1:0]    index;
  logic [mf3_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/median_filter_3x3.sv =====
// Top level of the streaming 3x3 median filter.
`timescale 1ns / 1ps
`default_nettype none
`include "median_filter_3x3_macros.svh"

// Streaming 3x3 median filter. Takes one beat per clock on in_bus, unless
// out_bus holds off the pipeline: a pixel (action 0) in raster order or a flush
// beat (action 1); after the last pixel of a frame send frame_width+1 flush
// beats. The result for the pixel at stream position p leaves on out_bus when
// the beat at p+width+1 has gone through the four pipeline registers (input,
// window, row sort, output); the input register loads on the accepting edge.
// The window is clipped at the frame border and the upper median is taken for
// an even count; frame_max carries the largest median so far and is complete
// on the beat with frame_last set. Throughput is one beat per clock while
// out_bus is not stalled, set by the two line-store RAMs (MAX_WIDTH deep),
// each doing one read and one write per beat; a one-column frame is served by
// forwarding the line-store write to the next read. Line stores need no
// clearing pass: entries never written fall outside the clipped window.
// Writing frame_width or frame_height (only while idle) restarts the frame.
module median_filter_3x3 #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 8
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mf3_cfg_if.sink    cfg_bus,
  mf3_in_if.sink     in_bus,
  mf3_out_if.source  out_bus
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int OB = $clog2(MAX_HEIGHT);
  localparam int RB = $clog2(MAX_HEIGHT + 2);

  localparam int W_RESET = (mf3_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : mf3_pkg::DIM_RESET;
  localparam int H_RESET = (mf3_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : mf3_pkg::DIM_RESET;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic          cfg_fire;
  logic          cfg_hit;
  logic [WB-1:0] w_r, w_nxt;
  logic [HB-1:0] h_r, h_nxt;

  assign cfg_bus.ready = 1'b1;
  assign cfg_fire      = cfg_bus.valid;

  // register decode with clamping to 1..MAX
  always_comb begin
    w_nxt   = w_r;
    h_nxt   = h_r;
    cfg_hit = 1'b0;
    if (cfg_fire) begin
      unique case (cfg_bus.index)
        mf3_pkg::REG_FRAME_WIDTH: begin
          cfg_hit = 1'b1;
          if (cfg_bus.data == '0) begin
            w_nxt = WB'(1);
          end else if (32'(cfg_bus.data) > MAX_WIDTH) begin
            w_nxt = WB'(MAX_WIDTH);
          end else begin
            w_nxt = WB'(cfg_bus.data);
          end
        end
        mf3_pkg::REG_FRAME_HEIGHT: begin
          cfg_hit = 1'b1;
          if (cfg_bus.data == '0) begin
            h_nxt = HB'(1);
          end else if (32'(cfg_bus.data) > MAX_HEIGHT) begin
            h_nxt = HB'(MAX_HEIGHT);
          end else begin
            h_nxt = HB'(cfg_bus.data);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WB'(W_RESET);
      h_r <= HB'(H_RESET);
    end else begin
      w_r <= w_nxt;
      h_r <= h_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------------
  logic in_ready;
  logic in_fire;
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_adv, s2_adv, s3_adv;
  logic s3_due_r;

  assign s3_adv   = s3_v_r && (!s3_due_r || !out_v_r || out_bus.ready);
  assign s2_adv   = s2_v_r && (!s3_v_r || s3_adv);
  assign s1_adv   = s1_v_r && (!s2_v_r || s2_adv);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_fire  = in_bus.valid && in_ready;

  assign in_bus.ready = in_ready;

  // ---------------------------------------------------------------------
  // Stream position and result position counters
  // ---------------------------------------------------------------------
  logic [CB-1:0] col_r, col_nxt;
  logic [RB-1:0] row_r, row_nxt;
  logic [CB-1:0] ocol_r, ocol_nxt;
  logic [OB-1:0] orow_r, orow_nxt;
  logic          pos_first;
  logic          col_wrap;
  logic          ocol_wrap;
  logic          due;
  logic          res_last;
  pix_t          pix_sel;
  mf3_pkg::pad_t pad;

  assign pos_first = (col_r == '0) && (row_r == '0);
  assign col_wrap  = (WB'(col_r) == (w_r - WB'(1)));
  assign ocol_wrap = (WB'(ocol_r) == (w_r - WB'(1)));
  // a result is due once the position passes width
  assign due       = (row_r >= RB'(2)) || ((row_r == RB'(1)) && (col_r != '0));
  assign res_last  = ocol_wrap && (HB'(orow_r) == (h_r - HB'(1)));
  // flush beats and beats past the frame store zero
  assign pix_sel   = ((in_bus.action != mf3_pkg::ACT_FLUSH) && (row_r < RB'(h_r))) ?
                     in_bus.pixel_in : '0;
  assign pad       = mf3_pkg::pad_masks(orow_r != '0,
                                        (HB'(orow_r) + HB'(1)) < h_r,
                                        ocol_r != '0,
                                        (WB'(ocol_r) + WB'(1)) < w_r);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (cfg_hit || (in_fire && due && res_last)) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end else if (in_fire) begin
      col_nxt = col_wrap ? '0 : col_r + CB'(1);
      row_nxt = col_wrap ? row_r + RB'(1) : row_r;
      if (due) begin
        ocol_nxt = ocol_wrap ? '0 : ocol_r + CB'(1);
        orow_nxt = ocol_wrap ? orow_r + OB'(1) : orow_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: accepted beat, line-store read in flight
  // ---------------------------------------------------------------------
  pix_t               s1_pix_r;
  logic [CB-1:0]      s1_col_r;
  logic               s1_first_r;
  mf3_pkg::item_ctl_t s1_ctl_r;
  logic               s1_bp_r;
  pix_t               s1_bp_top_r;
  pix_t               s1_bp_mid_r;
  pix_t               up_q, lo_q;
  pix_t               top_sel, mid_sel;

  // forward the line-store write when the next read hits the same column
  assign top_sel = s1_bp_r ? s1_bp_top_r : up_q;
  assign mid_sel = s1_bp_r ? s1_bp_mid_r : lo_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r      <= pix_sel;
      s1_col_r      <= col_r;
      s1_first_r    <= pos_first;
      s1_ctl_r.due  <= due;
      s1_ctl_r.last <= res_last;
      s1_ctl_r.pad  <= pad;
      s1_bp_r       <= s1_adv && (s1_col_r == col_r);
      s1_bp_top_r   <= mid_sel;
      s1_bp_mid_r   <= s1_pix_r;
    end
  end

  // line stores: upper holds two rows back, lower one row back
  mf3_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (mid_sel),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (up_q)
  );

  mf3_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_lower (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (lo_q)
  );

  // ---------------------------------------------------------------------
  // Stage 2: 3x3 window
  // ---------------------------------------------------------------------
  pix_t               win_r   [mf3_pkg::WIN_CELLS];
  pix_t               win_nxt [mf3_pkg::WIN_CELLS];
  mf3_pkg::item_ctl_t s2_ctl_r;

  // shift columns left, new right column from the line stores
  always_comb begin
    int r;
    for (r = 0; r < 3; r++) begin
      win_nxt[r*3 + 0] = s1_first_r ? '0 : win_r[r*3 + 1];
      win_nxt[r*3 + 1] = s1_first_r ? '0 : win_r[r*3 + 2];
    end
    win_nxt[2] = top_sel;
    win_nxt[5] = mid_sel;
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (!s2_v_r || s2_adv) begin
      s2_v_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_r    <= win_nxt;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: border padding and per-row sort
  // ---------------------------------------------------------------------
  pix_t padv [mf3_pkg::WIN_CELLS];
  pix_t row_lo [3];
  pix_t row_md [3];
  pix_t row_hi [3];
  pix_t s3_lo_r [3];
  pix_t s3_md_r [3];
  pix_t s3_hi_r [3];
  logic s3_last_r;

  always_comb begin
    int i;
    for (i = 0; i < mf3_pkg::WIN_CELLS; i++) begin
      if (s2_ctl_r.pad.keep[i]) begin
        padv[i] = win_r[i];
      end else begin
        padv[i] = s2_ctl_r.pad.low[i] ? '0 : '1;
      end
    end
    for (i = 0; i < 3; i++) begin
      row_lo[i] = min2(min2(padv[i*3], padv[i*3 + 1]), padv[i*3 + 2]);
      row_hi[i] = max2(max2(padv[i*3], padv[i*3 + 1]), padv[i*3 + 2]);
      row_md[i] = med3(padv[i*3], padv[i*3 + 1], padv[i*3 + 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (!s3_v_r || s3_adv) begin
      s3_v_r <= s2_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_lo_r   <= row_lo;
      s3_md_r   <= row_md;
      s3_hi_r   <= row_hi;
      s3_due_r  <= s2_ctl_r.due;
      s3_last_r <= s2_ctl_r.last;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: median of row results, running maximum
  // ---------------------------------------------------------------------
  pix_t med_val;
  pix_t max_nxt;
  pix_t out_med_r;
  pix_t out_max_r;
  pix_t run_max_r;
  logic out_last_r;

  assign med_val = med3(max2(max2(s3_lo_r[0], s3_lo_r[1]), s3_lo_r[2]),
                        med3(s3_md_r[0], s3_md_r[1], s3_md_r[2]),
                        min2(min2(s3_hi_r[0], s3_hi_r[1]), s3_hi_r[2]));
  assign max_nxt = max2(med_val, run_max_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      run_max_r <= '0;
    end else begin
      if (s3_adv && s3_due_r) begin
        out_v_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_hit) begin
        run_max_r <= '0;
      end else if (s3_adv && s3_due_r) begin
        run_max_r <= s3_last_r ? '0 : max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && s3_due_r) begin
      out_med_r  <= med_val;
      out_max_r  <= max_nxt;
      out_last_r <= s3_last_r;
    end
  end

  assign out_bus.valid      = out_v_r;
  assign out_bus.median_out = out_med_r;
  assign out_bus.frame_last = out_last_r;
  assign out_bus.frame_max  = out_max_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // same-column forwarding: one-column frames, or the first beat after a frame end
  `MF3_ASSERT_IMP(a_res_pos_in_frame, clk, rst_n, 1'b1, (HB'(orow_r) < h_r) && (WB'(ocol_r) < w_r), "result position outside frame")
  `MF3_ASSERT_NXT(a_restart_after_last, clk, rst_n, in_fire && due && res_last, (col_r == '0) && (row_r == '0) && (ocol_r == '0) && (orow_r == '0), "counters not cleared after last result")
  `MF3_ASSERT_IMP(a_forward_width_one, clk, rst_n, s1_v_r && s1_bp_r, (w_r == WB'(1)) || s1_first_r, "line-store forwarding outside one-column frame")
  `MF3_ASSERT_IMP(a_out_from_stage3, clk, rst_n, $rose(out_v_r), $past(s3_adv && s3_due_r), "result appeared without a due beat")
  `MF3_ASSERT_IMP(a_max_covers_median, clk, rst_n, out_v_r, out_max_r >= out_med_r, "frame maximum below shown median")

endmodule

`default_nettype wire

// ===== rtl/mf3_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
